>>> hw/rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants and types for the sliding window min/max filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 32;
    localparam int WLEN_W     = 7;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int LEN_W      = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTREME_MODE  = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Control broadcast to every cell of the window chain
    typedef struct packed {
        logic shift;     // move samples one cell toward the old end
        logic scan;      // advance the running extreme one cell per cycle
        logic want_max;  // 1: keep larger value, 0: keep smaller
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hw/rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One window slot: holds a sample and passes a running extreme to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_cell (
    input  wire                  i_clk,
    input  swmm_pkg::t_cell_ctrl i_ctrl,
    input  wire                  i_use,    // slot lies inside the window
    input  swmm_pkg::t_sample    i_value,  // sample from the newer neighbor
    output swmm_pkg::t_sample    o_value,
    input  swmm_pkg::t_sample    i_best,   // extreme over the newer slots
    output swmm_pkg::t_sample    o_best
);

    swmm_pkg::t_sample r_value;
    swmm_pkg::t_sample r_best;
    swmm_pkg::t_sample n_best;
    logic              more;

    // Strict compare: on a tie the newer value already in i_best wins
    assign more = i_ctrl.want_max ? (r_value > i_best) : (r_value < i_best);

    always_comb begin
        n_best = (i_use && more) ? r_value : i_best;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_value;
        end
        if (i_ctrl.scan) begin
            r_best <= n_best;
        end
    end

    assign o_value = r_value;
    assign o_best  = r_best;

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_min_max_core.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_core
// Min or max over the last window_length valid samples of a stream, built
// as a shift chain of cells through which a running extreme ripples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         i_s_axis_tvalid/o_..tready   tdata sample, tuser flags
//  m_axis    out        o_m_axis_tvalid/i_..tready   tdata extreme, tuser flags
//  cfg       in         i_cfg_valid/o_cfg_ready      index, data
//
//  A missing sample or one that leaves the window short goes straight to done.
//  A sample that fills the window goes through the scan state: the running
//  extreme crosses the whole cell chain, one cell per cycle.
//  One item is worked at a time; the next is taken while a result waits.
//  Reset (synchronous, active low) clears fill count, series state; resets config.
//  A stalled output holds the last result; the chain waits in the done state.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input stream
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire [31:0] i_s_axis_tdata,   // [31:0] sample_value
    input  wire [1:0]  i_s_axis_tuser,   // [0] sample_missing, [1] series_start
    // result stream
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] window_extreme
    output logic [1:0] o_m_axis_tuser,   // [0] extreme_valid, [1] missing_after_start
    // configuration
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [1:0]  i_cfg_index,
    input  wire [6:0]  i_cfg_data
);

    localparam int N = swmm_pkg::WINDOW_MAX;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [swmm_pkg::WLEN_W-1:0] r_wlen;
    logic                        r_mode;
    logic [swmm_pkg::LEN_W-1:0]  r_fill, n_fill;
    logic                        r_begun, n_begun;
    logic [swmm_pkg::CNT_W-1:0]  r_scan_cnt;

    // pending result
    swmm_pkg::t_sample r_res;
    logic              r_res_chain;  // value comes from the end of the chain
    logic              r_res_valid;
    logic              r_res_flag;

    logic              r_out_valid;
    swmm_pkg::t_sample r_out_data;
    logic [1:0]        r_out_user;

    logic [swmm_pkg::LEN_W-1:0] len_raw, len_eff;
    logic                       in_fire, out_free;
    logic                       missing, start;
    swmm_pkg::t_cell_ctrl       ctrl;

    swmm_pkg::t_sample val_chain  [N+1];
    swmm_pkg::t_sample best_chain [N+1];
    logic [N-1:0]      use_slot;

    // nothing is taken while reset is held
    assign o_cfg_ready     = i_rst_n;
    assign o_s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign missing         = i_s_axis_tuser[0];
    assign start           = i_s_axis_tuser[1];

    // window length: zero acts as one, saturates at the chain length
    always_comb begin
        len_raw = swmm_pkg::LEN_W'(r_wlen);
        if (len_raw == '0) begin
            len_eff = swmm_pkg::LEN_W'(1);
        end else if (len_raw > swmm_pkg::LEN_W'(N)) begin
            len_eff = swmm_pkg::LEN_W'(N);
        end else begin
            len_eff = len_raw;
        end
    end

    always_comb begin
        ctrl.shift    = in_fire && !missing;
        ctrl.scan     = (r_state == ST_SCAN);
        ctrl.want_max = r_mode;
    end

    assign val_chain[0]  = swmm_pkg::t_sample'(i_s_axis_tdata);
    assign best_chain[0] = val_chain[1];

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign use_slot[g] = (swmm_pkg::LEN_W'(g) < len_eff);

        swmm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_use   (use_slot[g]),
            .i_value (val_chain[g]),
            .o_value (val_chain[g+1]),
            .i_best  (best_chain[g]),
            .o_best  (best_chain[g+1])
        );
    end

    // series bookkeeping at accept
    always_comb begin
        n_fill  = start ? '0 : r_fill;
        n_begun = start ? 1'b0 : r_begun;
        if (!missing) begin
            if (n_fill < swmm_pkg::LEN_W'(N)) begin
                n_fill = n_fill + swmm_pkg::LEN_W'(1);
            end
            n_begun = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (!missing && n_fill >= len_eff) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (r_scan_cnt == swmm_pkg::CNT_W'(N - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wlen      <= swmm_pkg::WLEN_W'(1);
            r_mode      <= 1'b0;
            r_fill      <= '0;
            r_begun     <= 1'b0;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    swmm_pkg::CFG_WINDOW_LENGTH: r_wlen <= i_cfg_data;
                    swmm_pkg::CFG_EXTREME_MODE:  r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_fill  <= n_fill;
                r_begun <= n_begun;
            end

            if (r_state == ST_SCAN) begin
                r_scan_cnt <= r_scan_cnt + swmm_pkg::CNT_W'(1);
            end else begin
                r_scan_cnt <= '0;
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res       <= '0;
            r_res_chain <= !missing && (n_fill >= len_eff);
            r_res_valid <= !missing && (n_fill >= len_eff);
            r_res_flag  <= missing && r_begun && !start;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= r_res_chain ? best_chain[N] : r_res;
            r_out_user <= {r_res_flag, r_res_valid};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

>>> test/tb_sliding_window_min_max_core.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max_core
// Self-checking bench for the sliding window min/max filter. A queue-fed
// driver streams samples, a monitor checks every result against an in-bench
// model of the window, with random stalls on both streams and config changes
// between phases.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max_core;

    localparam logic [swmm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [swmm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int HOLD_LEN = 300;
    localparam int NUM_PHASES = 12;

    typedef struct packed {
        swmm_pkg::t_sample value;
        logic              missing;
        logic              start;
    } t_sample_item;

    typedef struct packed {
        swmm_pkg::t_sample extreme;
        logic              valid;
        logic              flag;
    } t_result_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [31:0]  o_m_axis_tdata;
    wire [1:0]   o_m_axis_tuser;
    wire         o_cfg_ready;

    sliding_window_min_max_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // model state of the filter
    swmm_pkg::t_sample win_store [swmm_pkg::WINDOW_MAX];
    int unsigned wr_pos = 0;
    int unsigned fill_cnt = 0;
    logic        begun = 1'b0;
    logic [6:0]  cfg_len = 7'd1;
    logic        cfg_max = 1'b0;

    t_sample_item pending_samples[$];
    t_result_item expected_extremes[$];
    t_sample_item on_bus;

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  src_pause = 1'b0;
    bit  hold_trigger = 1'b0;
    int  hold_left = 0;
    int  n_err = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_full = 0;
    int  n_flags = 0;
    int  n_starts = 0;
    int  n_writes = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_result_item filter_sample(t_sample_item s);
        t_result_item      r;
        int unsigned       eff_len;
        int unsigned       pos;
        int unsigned       age;
        swmm_pkg::t_sample best;
        swmm_pkg::t_sample v;
        r = '0;
        if (s.start) begin
            wr_pos = 0;
            fill_cnt = 0;
            begun = 1'b0;
        end
        if (s.missing) begin
            r.flag = begun;
        end else begin
            win_store[wr_pos] = s.value;
            wr_pos = (wr_pos + 1) % swmm_pkg::WINDOW_MAX;
            if (fill_cnt < swmm_pkg::WINDOW_MAX) fill_cnt++;
            begun = 1'b1;
            eff_len = (cfg_len == 0) ? 1 :
                      (cfg_len > swmm_pkg::WINDOW_MAX) ? swmm_pkg::WINDOW_MAX : cfg_len;
            if (fill_cnt >= eff_len) begin
                best = s.value;
                for (age = 1; age < eff_len; age++) begin
                    pos = (wr_pos + 2 * swmm_pkg::WINDOW_MAX - 1 - age) %
                          swmm_pkg::WINDOW_MAX;
                    v = win_store[pos];
                    if (cfg_max ? (v > best) : (v < best)) best = v;
                end
                r.extreme = best;
                r.valid = 1'b1;
            end
        end
        return r;
    endfunction

    // driver: predict on acceptance, then offer the next queued item
    always @(posedge i_clk) begin : drive_proc
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                expected_extremes.push_back(filter_sample(on_bus));
                n_items++;
                if (on_bus.start) n_starts++;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (pending_samples.size() != 0 && !src_pause &&
                    $urandom_range(99) >= src_idle_pct) begin
                    on_bus = pending_samples.pop_front();
                    s_valid <= 1'b1;
                    s_data <= on_bus.value;
                    s_user <= {on_bus.start, on_bus.missing};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
        else if (hold_trigger) hold_left <= HOLD_LEN;
    end

    always @(posedge i_clk) begin : check_proc
        t_result_item got;
        t_result_item want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                got = {o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tuser[1]};
                n_results++;
                if (expected_extremes.size() == 0) begin
                    $error("result with nothing expected: extreme %0d",
                           $signed(got.extreme));
                    n_err++;
                end else begin
                    want = expected_extremes.pop_front();
                    if (got.extreme !== want.extreme) begin
                        $error("window_extreme: expected %0d, got %0d",
                               $signed(want.extreme), $signed(got.extreme));
                        n_err++;
                    end
                    if (got.valid !== want.valid) begin
                        $error("extreme_valid: expected %0b, got %0b", want.valid, got.valid);
                        n_err++;
                    end
                    if (got.flag !== want.flag) begin
                        $error("missing_after_start: expected %0b, got %0b",
                               want.flag, got.flag);
                        n_err++;
                    end
                    if (want.valid) n_full++;
                    if (want.flag) n_flags++;
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == swmm_pkg::CFG_WINDOW_LENGTH) cfg_len = val;
        else if (idx == swmm_pkg::CFG_EXTREME_MODE) cfg_max = val[0];
        n_writes++;
        @(posedge i_clk);
    endtask

    task automatic push_sample(input swmm_pkg::t_sample value, input logic missing,
                               input logic start);
        t_sample_item s;
        s.value = value;
        s.missing = missing;
        s.start = start;
        pending_samples.push_back(s);
    endtask

    function automatic swmm_pkg::t_sample rand_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed($urandom_range(8)) - 4;   // narrow range forces ties
            3: return '0;
            4: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input int count, input int miss_pct, input int start_pct);
        for (int i = 0; i < count; i++) begin
            push_sample(rand_value(), $urandom_range(99) < miss_pct,
                        $urandom_range(99) < start_pct);
        end
    endtask

    // checked at the falling edge, once the driver and monitor have settled
    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_valid || expected_extremes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [6:0] lens [NUM_PHASES];
        int         count;
        lens = '{7'd2, 7'd64, 7'd1, 7'd0, 7'd5, 7'd127, 7'd3, 7'd65, 7'd8, 7'd17, 7'd2, 7'd40};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 23;
        snk_idle_pct = 63;

        // directed: min over 3, leading missing, extremes, ties, restarts
        write_reg(CFG_SPARE_A, 7'h55);
        write_reg(CFG_SPARE_B, 7'h2A);
        write_reg(swmm_pkg::CFG_WINDOW_LENGTH, 7'd3);
        write_reg(swmm_pkg::CFG_EXTREME_MODE, 7'd0);
        push_sample(32'sd9, 1'b1, 1'b0);
        push_sample(32'sd9, 1'b1, 1'b1);
        push_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_sample(32'sh8000_0000, 1'b0, 1'b0);
        push_sample(32'sd0, 1'b0, 1'b0);
        push_sample(32'sd1, 1'b1, 1'b0);
        push_sample(-32'sd1, 1'b0, 1'b0);
        push_sample(32'sd5, 1'b0, 1'b0);
        push_sample(32'sd5, 1'b0, 1'b0);
        push_sample(32'sd5, 1'b0, 1'b0);
        push_sample(32'sd7, 1'b0, 1'b1);
        push_sample(32'sd0, 1'b1, 1'b1);
        push_sample(32'sd0, 1'b1, 1'b0);
        push_sample(32'sd1, 1'b0, 1'b0);
        push_sample(32'sd2, 1'b0, 1'b0);
        push_sample(32'sd3, 1'b0, 1'b0);
        wait_idle();

        // max, length zero behaves as one; length changes mid-series
        write_reg(swmm_pkg::CFG_WINDOW_LENGTH, 7'd0);
        write_reg(swmm_pkg::CFG_EXTREME_MODE, 7'd1);
        push_sample(32'sh8000_0000, 1'b0, 1'b0);
        push_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_sample(32'sd4, 1'b1, 1'b0);
        push_sample(-32'sd5, 1'b0, 1'b0);
        wait_idle();
        write_reg(swmm_pkg::CFG_WINDOW_LENGTH, 7'd127);
        push_sample(32'sd11, 1'b0, 1'b0);
        push_sample(-32'sd11, 1'b0, 1'b0);
        wait_idle();
        write_reg(swmm_pkg::CFG_WINDOW_LENGTH, 7'd4);
        push_sample(32'sd6, 1'b0, 1'b0);
        push_sample(32'sd6, 1'b0, 1'b0);
        wait_idle();

        for (int k = 0; k < NUM_PHASES; k++) begin
            if (k < 4) begin
                src_idle_pct = 23;
                snk_idle_pct = 63;
            end else if (k < 8) begin
                src_idle_pct = 63;
                snk_idle_pct = 23;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_reg(swmm_pkg::CFG_WINDOW_LENGTH, lens[k]);
            write_reg(swmm_pkg::CFG_EXTREME_MODE, 7'($urandom_range(1)));
            if (lens[k] >= 33) begin
                count = 55;
                queue_random(count, 5, 0);
            end else begin
                count = 25;
                // one noisy phase: many missing samples and restarts
                queue_random(count, (k == 10) ? 35 : 5, (k == 10) ? 10 : 2);
            end
            if (k == 2) begin
                while (pending_samples.size() > count / 2) @(negedge i_clk);
                src_pause = 1'b1;
                @(negedge i_clk);
                while (expected_extremes.size() != 0 || s_valid) @(negedge i_clk);
                src_pause = 1'b0;
            end
            if (k == 8) begin
                hold_trigger <= 1'b1;
                @(posedge i_clk);
                hold_trigger <= 1'b0;
            end
            wait_idle();
        end

        repeat (swmm_pkg::WINDOW_MAX + 8) @(posedge i_clk);
        if (expected_extremes.size() != 0) begin
            $error("%0d expected results never arrived", expected_extremes.size());
            n_err++;
        end
        $display("Run covered %0d samples, %0d results (%0d full-window extremes,", n_items,
                 n_results, n_full);
        $display("%0d missing-after-start flags), %0d restarts, %0d register writes.",
                 n_flags, n_starts, n_writes);
        if (n_err == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sliding_window_min_max_core.f
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_cell.sv
hw/rtl/sliding_window_min_max_core.sv
test/tb_sliding_window_min_max_core.sv
